// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level to check the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during rst.
`define PKWRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst.
`define PKWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pkwrl_pkg.sv =====
// Package with types and constants of the per-key window rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package pkwrl_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 48;
  localparam int WIN_W    = 32;
  localparam int CNT_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_MS_RESET      = 32'd60000;
  localparam logic [CNT_W-1:0] MAX_PER_WINDOW_RESET = 16'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX            = 16'hFFFF;

  typedef struct packed {
    logic [KEY_W-1:0]  publisher_key;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [SLOT_W-1:0] slot_used;
    logic              replaced;
    logic [CNT_W-1:0]  count_now;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] win_begin;
    logic [CNT_W-1:0]  count;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/pkwrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pkwrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/pkwrl_ctrl.sv =====
// Controller state machine that sequences the slot scan, evaluation and update.
`timescale 1ns / 1ps
`default_nettype none
module pkwrl_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire pkwrl_pkg::dp_status_t status,
  output pkwrl_pkg::ctrl_cmd_t       cmd,
  output logic                       busy
);

  pkwrl_pkg::state_t state;
  pkwrl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pkwrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pkwrl_pkg::ST_IDLE: begin
        if (start) begin
          state_next = pkwrl_pkg::ST_SCAN;
        end
      end
      pkwrl_pkg::ST_SCAN: begin
        if (status.hit || status.last) begin
          state_next = pkwrl_pkg::ST_EVAL;
        end
      end
      pkwrl_pkg::ST_EVAL:  state_next = pkwrl_pkg::ST_WRITE;
      pkwrl_pkg::ST_WRITE: state_next = pkwrl_pkg::ST_IDLE;
      default:             state_next = pkwrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      pkwrl_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pkwrl_pkg::ST_SCAN:  cmd.scan  = 1'b1;
      pkwrl_pkg::ST_EVAL:  cmd.eval  = 1'b1;
      pkwrl_pkg::ST_WRITE: cmd.write = 1'b1;
      default:             busy      = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/pkwrl_dp.sv =====
// Datapath: configuration registers, slot table, scan compare, window and count update.
`timescale 1ns / 1ps
`default_nettype none
module pkwrl_dp #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pkwrl_pkg::req_t                      request,
  input  wire logic                                 cfg_we,
  input  wire logic [pkwrl_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [pkwrl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire pkwrl_pkg::ctrl_cmd_t                 cmd,
  output pkwrl_pkg::dp_status_t                     status,
  output logic                                      done,
  output pkwrl_pkg::rsp_t                           result
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [pkwrl_pkg::WIN_W-1:0]  window_ms;
  logic [pkwrl_pkg::CNT_W-1:0]  max_per_window;

  logic [pkwrl_pkg::KEY_W-1:0]  key_q;
  logic [pkwrl_pkg::TIME_W-1:0] now_q;

  logic [NUM_SLOTS-1:0] vld;
  logic                 vld_rd;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     cmp_idx;
  pkwrl_pkg::slot_t     ram_rdata;
  pkwrl_pkg::slot_t     cur;
  pkwrl_pkg::slot_t     wr_slot;

  logic [pkwrl_pkg::TIME_W-1:0] best_ws;
  logic [IDX_W-1:0]             best_idx;
  logic                         take_cur;
  logic [IDX_W-1:0]             best_idx_next;
  logic [pkwrl_pkg::TIME_W-1:0] best_ws_next;

  logic [IDX_W-1:0]             sel_idx;
  logic [pkwrl_pkg::TIME_W-1:0] sel_ws;
  logic [pkwrl_pkg::CNT_W-1:0]  sel_cnt;
  logic                         sel_rep;
  logic                         restart;

  logic [pkwrl_pkg::TIME_W-1:0] elapsed;
  logic [pkwrl_pkg::CNT_W-1:0]  cnt_base;
  logic [pkwrl_pkg::CNT_W-1:0]  cnt_new;
  logic [pkwrl_pkg::TIME_W-1:0] ws_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms      <= pkwrl_pkg::WINDOW_MS_RESET;
      max_per_window <= pkwrl_pkg::MAX_PER_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pkwrl_pkg::REG_WINDOW_MS:      window_ms      <= cfg_data;
        pkwrl_pkg::REG_MAX_PER_WINDOW: max_per_window <= cfg_data[pkwrl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  pkwrl_ram #(
    .WIDTH ($bits(pkwrl_pkg::slot_t)),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (sel_idx),
    .wdata (wr_slot),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Slots never written since reset read as all zero.
  always_comb begin
    cur = vld_rd ? ram_rdata : '0;
  end

  always_comb begin
    status.hit    = cmd.scan && (cur.key == key_q);
    status.last   = cmd.scan && (cmp_idx == LAST_IDX);
    take_cur      = (cmp_idx == '0) || (cur.win_begin < best_ws);
    best_idx_next = take_cur ? cmp_idx : best_idx;
    best_ws_next  = take_cur ? cur.win_begin : best_ws;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_idx <= '0;
      done   <= 1'b0;
    end else begin
      done <= cmd.write;
      if (cmd.load) begin
        rd_idx <= IDX_W'(1);
      end else if (cmd.scan) begin
        if (rd_idx != LAST_IDX) begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end else if (cmd.write) begin
        rd_idx       <= '0;
        vld[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_rd <= vld[rd_idx];
    if (cmd.load) begin
      key_q   <= request.publisher_key;
      now_q   <= request.now_ms;
      cmp_idx <= '0;
    end
    if (cmd.scan) begin
      cmp_idx  <= rd_idx;
      best_idx <= best_idx_next;
      best_ws  <= best_ws_next;
      if (status.hit) begin
        sel_idx <= cmp_idx;
        sel_ws  <= cur.win_begin;
        sel_cnt <= cur.count;
        sel_rep <= 1'b0;
      end else if (status.last) begin
        sel_idx <= best_idx_next;
        sel_ws  <= now_q;
        sel_cnt <= '0;
        sel_rep <= 1'b1;
      end
    end
    if (cmd.eval) begin
      restart <= (elapsed >= {{(pkwrl_pkg::TIME_W - pkwrl_pkg::WIN_W){1'b0}}, window_ms});
    end
    if (cmd.write) begin
      result.allowed   <= (cnt_new <= max_per_window);
      result.slot_used <= pkwrl_pkg::SLOT_W'(sel_idx);
      result.replaced  <= sel_rep;
      result.count_now <= cnt_new;
    end
  end

  always_comb begin
    elapsed  = now_q - sel_ws;
    cnt_base = restart ? '0 : sel_cnt;
    cnt_new  = (cnt_base == pkwrl_pkg::COUNT_MAX) ? cnt_base
                                                  : cnt_base + pkwrl_pkg::CNT_W'(1);
    ws_new   = restart ? now_q : sel_ws;
    wr_slot.key       = key_q;
    wr_slot.win_begin = ws_new;
    wr_slot.count     = cnt_new;
  end

endmodule
`default_nettype wire

// ===== hdl/per_key_window_rate_limiter.sv =====
// Top level of the per-key window rate limiter.
//
//   Channel   Ports                         Transfer
//   request   start, busy, request          start high while busy low
//   result    done, result                  done high for one cycle
//   config    cfg_we, cfg_idx, cfg_data     cfg_we high
//
// For a request that matches slot k, the scan stops at slot k; a request that matches no
// slot scans all NUM_SLOTS slots. The scan reads the slot RAM one slot per cycle, and
// is followed by the EVAL and WRITE states; done is registered from WRITE.
// A new request may be accepted in the cycle that done is high.
// Reset marks every slot empty through per-slot valid bits, with no clearing pass.
// The result cannot be held off; it is presented for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module per_key_window_rate_limiter #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire pkwrl_pkg::req_t                  request,
  output logic                                  done,
  output pkwrl_pkg::rsp_t                       result,
  input  wire logic                             cfg_we,
  input  wire logic [pkwrl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pkwrl_pkg::CFG_DATA_W-1:0] cfg_data
);

  pkwrl_pkg::ctrl_cmd_t  cmd;
  pkwrl_pkg::dp_status_t status;

  pkwrl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pkwrl_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .result   (result)
  );

  `PKWRL_ASSERT_NOW(a_done_not_busy, done, !busy, "Result strobe while busy.")
  `PKWRL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted request did not set busy.")
  `PKWRL_ASSERT_NOW(a_done_after_busy, done, $past(busy), "Result strobe without prior work.")
  `PKWRL_ASSERT_NOW(a_count_nonzero, done, result.count_now != '0, "Result count is zero.")

endmodule
`default_nettype wire

// ===== sim/per_key_window_rate_limiter_tb.sv =====
// Self-checking testbench for the per-key window rate limiter with directed and random tests.
`timescale 1ns / 1ps
module per_key_window_rate_limiter_tb;
  import pkwrl_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_GAP = 12;
  localparam int POOL = 24;
  localparam int POOL_IDX_W = $clog2(POOL);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [WIN_W-1:0] WINDOW_LONGEST = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_LATEST = 48'hFFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [KEY_W-1:0] slot_keys [NUM_SLOTS];
  logic [TIME_W-1:0] slot_starts [NUM_SLOTS];
  logic [CNT_W-1:0] slot_counts [NUM_SLOTS];
  logic [WIN_W-1:0] window_len;
  logic [CNT_W-1:0] rate_cap;

  rsp_t pending_verdicts [$];
  int accepted_reqs = 0;
  int mismatches = 0;
  int cycles = 0;
  int idle_pct;

  per_key_window_rate_limiter #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic rsp_t predict_admission(req_t req);
    rsp_t verdict;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] oldest;
    bit hit;
    logic [TIME_W-1:0] age;
    sel = '0;
    oldest = '0;
    hit = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!hit) begin
        if (slot_keys[IDX_W'(i)] == req.publisher_key) begin
          hit = 1'b1;
          sel = IDX_W'(i);
        end else if (slot_starts[IDX_W'(i)] < slot_starts[oldest]) begin
          oldest = IDX_W'(i);
        end
      end
    end
    if (!hit) begin
      sel = oldest;
      slot_keys[sel] = req.publisher_key;
      slot_counts[sel] = '0;
      slot_starts[sel] = req.now_ms;
    end
    age = req.now_ms - slot_starts[sel];
    if (age >= TIME_W'(window_len)) begin
      slot_starts[sel] = req.now_ms;
      slot_counts[sel] = '0;
    end
    if (slot_counts[sel] != COUNT_MAX) slot_counts[sel] = slot_counts[sel] + CNT_W'(1);
    verdict.allowed = (slot_counts[sel] <= rate_cap);
    verdict.slot_used = SLOT_W'(sel);
    verdict.replaced = !hit;
    verdict.count_now = slot_counts[sel];
    return verdict;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_keys[IDX_W'(i)] = '0;
        slot_starts[IDX_W'(i)] = '0;
        slot_counts[IDX_W'(i)] = '0;
      end
      window_len = WINDOW_MS_RESET;
      rate_cap = MAX_PER_WINDOW_RESET;
      pending_verdicts.delete();
    end else begin
      if (done) begin
        if (pending_verdicts.size() == 0) begin
          $error("Result arrived with no request outstanding.");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result.allowed !== want.allowed) begin
            $error("allowed: expected %0d, actual %0d", want.allowed, result.allowed);
            mismatches++;
          end
          if (result.slot_used !== want.slot_used) begin
            $error("slot_used: expected %0d, actual %0d", want.slot_used, result.slot_used);
            mismatches++;
          end
          if (result.replaced !== want.replaced) begin
            $error("replaced: expected %0d, actual %0d", want.replaced, result.replaced);
            mismatches++;
          end
          if (result.count_now !== want.count_now) begin
            $error("count_now: expected %0d, actual %0d", want.count_now, result.count_now);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        pending_verdicts.push_back(predict_admission(request));
        accepted_reqs++;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_WINDOW_MS: window_len = cfg_data[WIN_W-1:0];
          REG_MAX_PER_WINDOW: rate_cap = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now);
    int gap;
    int target;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    target = accepted_reqs + 1;
    start <= 1'b1;
    request <= {key, now};
    do @(negedge clk); while (accepted_reqs < target);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_key_zero;
    send_request('0, 48'd5);
    drain();
  endtask

  task automatic test_long_window_count;
    write_reg(REG_WINDOW_MS, WINDOW_LONGEST);
    write_reg(REG_MAX_PER_WINDOW, 32'hABCD_FFFF);
    repeat (20) send_request('0, 48'd5);
    drain();
    write_reg(REG_MAX_PER_WINDOW, 32'd15);
    send_request('0, 48'd5);
    drain();
  endtask

  task automatic test_field_extremes;
    write_reg(REG_MAX_PER_WINDOW, 32'd1);
    send_request(KEY_ALL_ONES, TIME_LATEST);
    send_request(64'h8000_0000_0000_0000, '0);
    send_request(64'h1, 48'h8000_0000_0000);
    send_request(KEY_ALL_ONES, TIME_LATEST);
    drain();
  endtask

  task automatic test_rate_limit;
    write_reg(REG_WINDOW_MS, 32'd100);
    write_reg(REG_MAX_PER_WINDOW, 32'd3);
    repeat (5) send_request(64'h0123_4567_89AB_CDEF, 48'd1000);
    send_request(64'h0123_4567_89AB_CDEF, 48'd1099);
    send_request(64'h0123_4567_89AB_CDEF, 48'd1100);
    drain();
  endtask

  task automatic test_window_restart;
    write_reg(REG_WINDOW_MS, 32'd1);
    send_request(64'h5555_AAAA_5555_AAAA, 48'd1000);
    send_request(64'h5555_AAAA_5555_AAAA, 48'd999);
    drain();
    write_reg(REG_WINDOW_MS, 32'd0);
    send_request(64'h5555_AAAA_5555_AAAA, 48'd999);
    send_request(64'h5555_AAAA_5555_AAAA, 48'd999);
    drain();
  endtask

  task automatic test_zero_limit_and_spare_regs;
    write_reg(REG_WINDOW_MS, 32'd500);
    write_reg(REG_MAX_PER_WINDOW, 32'd0);
    send_request(64'hFEDC_BA98_7654_3210, 48'd2000);
    drain();
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h0000_0001);
    send_request(64'hFEDC_BA98_7654_3210, 48'd2001);
    drain();
  endtask

  task automatic test_random_traffic(input int items, input int pct,
                                     input logic [WIN_W-1:0] win, input logic [CNT_W-1:0] cap);
    logic [KEY_W-1:0] key_pool [POOL];
    logic [TIME_W-1:0] clock_ms;
    int pick;
    idle_pct = pct;
    write_reg(REG_WINDOW_MS, win);
    write_reg(REG_MAX_PER_WINDOW, {CNT_W'($urandom), cap});
    for (int i = 0; i < POOL; i++) key_pool[POOL_IDX_W'(i)] = {$urandom, $urandom};
    key_pool[0] = '0;
    clock_ms = TIME_W'({$urandom, $urandom});
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        clock_ms = clock_ms + TIME_W'($urandom_range(0, 6));
        send_request(key_pool[POOL_IDX_W'($urandom_range(POOL - 1))], clock_ms);
      end else if (pick < 93) begin
        clock_ms = clock_ms - TIME_W'($urandom_range(0, 80));
        send_request(key_pool[POOL_IDX_W'($urandom_range(POOL - 1))], clock_ms);
      end else begin
        send_request({$urandom, $urandom}, TIME_W'({$urandom, $urandom}));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_key_zero();
    test_long_window_count();
    idle_pct = 21;
    test_field_extremes();
    test_rate_limit();
    test_window_restart();
    test_zero_limit_and_spare_regs();
    test_random_traffic(350, 21, WIN_W'($urandom_range(1, 64)), CNT_W'($urandom_range(1, 6)));
    test_random_traffic(350, 50, WINDOW_LONGEST, COUNT_MAX);
    test_random_traffic(175, 0, 32'd1, 16'd1);
    test_random_traffic(175, 0, WIN_W'($urandom_range(8, 40)), 16'd2);

    drain();
    repeat (NUM_SLOTS + 4) @(negedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
